@@ rtl/core/midi_track_event_parser_unit_macros.svh @@
// Assertion macros used by the top level of the track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MTEP_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mtep assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mtep assertion failed");

`else

`define MTEP_ASSERT_SAME(label, clk, rst, pre, post)
`define MTEP_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

@@ rtl/core/mtep_pkg.sv @@
// Types and constants of the MIDI track event parser.
`default_nettype none

package mtep_pkg;

   typedef enum logic [1:0] {
      KIND_NOTE      = 2'd0,
      KIND_META_HEAD = 2'd1,
      KIND_META_DATA = 2'd2,
      KIND_ERROR     = 2'd3
   } kind_type;

   localparam int DELTA_WIDTH = 28;

   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] SYSEX_END    = 8'hF7;
   localparam logic [7:0] META_EOT     = 8'h2F;
   localparam logic [3:0] HI_PROGRAM   = 4'hC;
   localparam logic [3:0] HI_PRESSURE  = 4'hD;
   // Top three bits shared by note-off and note-on status bytes (0x80..0x9F).
   localparam logic [2:0] NOTE_PREFIX  = 3'b100;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_start;
      logic       chunk_end;
      logic [3:0] track_index;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [DELTA_WIDTH-1:0] delta_time;
      logic [7:0]             status_or_type;
      logic [3:0]             track_tag;
      logic [7:0]             first_data;
      logic [6:0]             second_data;
      logic [7:0]             meta_length;
      logic                   run_last;
      logic                   end_of_track;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/mtep_parser.sv @@
// Byte-wise track parser: event state, delta decoding and result forming.
`default_nettype none

module mtep_parser (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take,
   input  wire mtep_pkg::req_type req,
   output logic                 res_valid,
   output mtep_pkg::rsp_type    res
);

   typedef enum logic [3:0] {
      PH_DELTA,
      PH_VLQ,
      PH_STATUS,
      PH_DATA1,
      PH_DATA2,
      PH_MTYPE,
      PH_MLEN,
      PH_MDATA,
      PH_SYSEX
   } phase_type;

   phase_type                        phase_ff, phase_in, cur_phase;
   logic [mtep_pkg::DELTA_WIDTH-1:0] delta_ff, delta_in, cur_delta;
   logic [7:0]                       status_ff, status_in, cur_status;
   logic [7:0]                       mtype_ff, mtype_in, cur_mtype;
   logic [7:0]                       left_ff, left_in, cur_left;
   logic [7:0]                       fdata_ff, fdata_in, cur_fdata;
   logic                             done_ff, done_in, cur_done;
   logic [7:0]                       b;

   assign b = req.data_byte;

   always_comb begin
      // A chunk start clears the parser before this word is taken.
      cur_phase  = req.chunk_start ? PH_DELTA : phase_ff;
      cur_delta  = req.chunk_start ? '0 : delta_ff;
      cur_status = req.chunk_start ? 8'd0 : status_ff;
      cur_mtype  = req.chunk_start ? 8'd0 : mtype_ff;
      cur_left   = req.chunk_start ? 8'd0 : left_ff;
      cur_fdata  = req.chunk_start ? 8'd0 : fdata_ff;
      cur_done   = req.chunk_start ? 1'b0 : done_ff;

      phase_in  = cur_phase;
      delta_in  = cur_delta;
      status_in = cur_status;
      mtype_in  = cur_mtype;
      left_in   = cur_left;
      fdata_in  = cur_fdata;
      done_in   = cur_done;
      res       = '0;
      res_valid = 1'b0;

      if (!cur_done) begin
         unique case (cur_phase)
            PH_DELTA, PH_VLQ: begin
               delta_in = {cur_delta[mtep_pkg::DELTA_WIDTH-8:0], b[6:0]};
               phase_in = b[7] ? PH_VLQ : PH_STATUS;
            end
            PH_STATUS: begin
               if (b == mtep_pkg::STATUS_META) begin
                  status_in = 8'd0;
                  phase_in  = PH_MTYPE;
               end else if (b == mtep_pkg::STATUS_SYSEX) begin
                  status_in = 8'd0;
                  phase_in  = PH_SYSEX;
               end else if (b[7]) begin
                  status_in = b;
                  phase_in  = PH_DATA1;
               end else if (!cur_status[7]) begin
                  // Data word with no running status: report and drop the rest.
                  res.kind           = mtep_pkg::KIND_ERROR;
                  res.delta_time     = cur_delta;
                  res.status_or_type = b;
                  res_valid          = 1'b1;
                  done_in            = 1'b1;
               end else begin
                  fdata_in = b;
                  if (cur_status[7:4] == mtep_pkg::HI_PROGRAM ||
                      cur_status[7:4] == mtep_pkg::HI_PRESSURE) begin
                     phase_in = PH_DELTA;
                     delta_in = '0;
                  end else begin
                     phase_in = PH_DATA2;
                  end
               end
            end
            PH_DATA1: begin
               fdata_in = b;
               if (cur_status[7:4] == mtep_pkg::HI_PROGRAM ||
                   cur_status[7:4] == mtep_pkg::HI_PRESSURE) begin
                  phase_in = PH_DELTA;
                  delta_in = '0;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               if (cur_status[7:5] == mtep_pkg::NOTE_PREFIX) begin
                  res.kind           = mtep_pkg::KIND_NOTE;
                  res.delta_time     = cur_delta;
                  res.status_or_type = cur_status;
                  res.first_data     = cur_fdata;
                  res.second_data    = b[6:0];
                  res_valid          = 1'b1;
               end
               phase_in = PH_DELTA;
               delta_in = '0;
            end
            PH_MTYPE: begin
               mtype_in = b;
               phase_in = PH_MLEN;
            end
            PH_MLEN: begin
               left_in            = b;
               fdata_in           = b;
               res.kind           = mtep_pkg::KIND_META_HEAD;
               res.delta_time     = cur_delta;
               res.status_or_type = cur_mtype;
               res.meta_length    = b;
               res_valid          = 1'b1;
               if (b == 8'd0) begin
                  res.run_last     = 1'b1;
                  res.end_of_track = (cur_mtype == mtep_pkg::META_EOT);
                  done_in          = (cur_mtype == mtep_pkg::META_EOT);
                  phase_in         = PH_DELTA;
                  delta_in         = '0;
               end else begin
                  phase_in = PH_MDATA;
               end
            end
            PH_MDATA: begin
               res.kind           = mtep_pkg::KIND_META_DATA;
               res.delta_time     = cur_delta;
               res.status_or_type = cur_mtype;
               res.first_data     = b;
               res.meta_length    = cur_fdata;
               res_valid          = 1'b1;
               left_in            = cur_left - 8'd1;
               if (left_in == 8'd0) begin
                  res.run_last     = 1'b1;
                  res.end_of_track = (cur_mtype == mtep_pkg::META_EOT);
                  done_in          = (cur_mtype == mtep_pkg::META_EOT);
                  phase_in         = PH_DELTA;
                  delta_in         = '0;
               end
            end
            PH_SYSEX: begin
               if (b == mtep_pkg::SYSEX_END) begin
                  phase_in = PH_DELTA;
                  delta_in = '0;
               end
            end
            default: begin
               phase_in = PH_DELTA;
               delta_in = '0;
            end
         endcase
      end

      if (req.chunk_end) begin
         // An event still open at the chunk end replaces any result of this word.
         if (!done_in && phase_in != PH_DELTA) begin
            res                = '0;
            res.kind           = mtep_pkg::KIND_ERROR;
            res.delta_time     = delta_in;
            res.status_or_type = b;
            res_valid          = 1'b1;
         end
         phase_in  = PH_DELTA;
         delta_in  = '0;
         status_in = 8'd0;
         mtype_in  = 8'd0;
         left_in   = 8'd0;
         fdata_in  = 8'd0;
         done_in   = 1'b0;
      end

      res.track_tag = req.track_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         delta_ff  <= '0;
         status_ff <= 8'd0;
         mtype_ff  <= 8'd0;
         left_ff   <= 8'd0;
         fdata_ff  <= 8'd0;
         done_ff   <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         delta_ff  <= delta_in;
         status_ff <= status_in;
         mtype_ff  <= mtype_in;
         left_ff   <= left_in;
         fdata_ff  <= fdata_in;
         done_ff   <= done_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/mtep_out_buf.sv @@
// Result register with a skid stage so that a stall does not stop input for one word.
`default_nettype none

module mtep_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mtep_pkg::rsp_type push_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mtep_pkg::rsp_type     rsp_data
);

   mtep_pkg::rsp_type main_ff, main_in, skid_ff, skid_in;
   logic              main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic              pop;

   assign pop       = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // No push can arrive while the skid stage is full.
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_in       = push_data;
         main_valid_in = push;
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/midi_track_event_parser_unit.sv @@
// Top level of the MIDI track event parser.
// Usage:
//   The req channel carries one byte of a track chunk body per word, with flags for
//   the first and last byte of the chunk and the track number. The rsp channel carries
//   decoded note events, meta headers, meta data bytes and format errors.
//   A byte yields zero or one result word.
//   Throughput is one byte per cycle while req_stall is low; the event state machine
//   updates once per byte. Each result is registered in an output stage.
//   When rsp stalls, one more result is caught in a skid stage; req_stall rises only
//   while that stage is occupied, and drops in the cycle after rsp takes a word.
//   Reset (synchronous) empties both output stages and returns the parser to the start
//   of an event with no running status. A chunk start byte clears the parser too.
`default_nettype none
`include "midi_track_event_parser_unit_macros.svh"

module midi_track_event_parser_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mtep_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mtep_pkg::rsp_type     rsp_data
);

   logic              take;
   logic              res_valid;
   logic              push;
   mtep_pkg::rsp_type res;

   assign take = req_valid && !req_stall;
   assign push = take && res_valid;

   mtep_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_data),
      .res_valid (res_valid),
      .res       (res)
   );

   mtep_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `MTEP_ASSERT_SAME(a_skid_needs_main, clock, reset, req_stall, rsp_valid)
   `MTEP_ASSERT_NEXT(a_push_on_stall_fills_skid, clock, reset,
      rsp_valid && rsp_stall && push && !req_stall, req_stall)
   `MTEP_ASSERT_SAME(a_eot_is_last, clock, reset,
      rsp_valid && rsp_data.end_of_track, rsp_data.run_last)

endmodule

`default_nettype wire
